// ===== rtl/core/tcw_pkg.sv =====
// Shared types, constants and helpers for the text console character writer.
// Used by tcw_ctrl, tcw_datapath and text_console_char_writer; no dependencies.
`default_nettype none

package tcw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TAB_WIDTH      = 8;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int COPY_END       = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;

  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int ADDR_W   = 11;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;
  localparam int SCROLL_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int PTR_W    = $clog2(CELL_COUNT);
  localparam int START_W  = SCROLL_W + COL_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUT  = 2'd0,
    OP_READ = 2'd1,
    OP_SET  = 2'd2
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTRIBUTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_TOP     = 2'd1;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [SCROLL_W-1:0] SCROLL_TOP_RESET = 5'd7;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_address;
    logic [COL_W-1:0]  new_column;
    logic [ROW_W-1:0]  new_row;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [ADDR_W-1:0] cursor_location;
    logic [COL_W-1:0]  cursor_col_out;
    logic [ROW_W-1:0]  cursor_row_out;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic copy_rd;
    logic copy_wr;
    logic blank_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic skip_copy;
    logic copy_last;
    logic ptr_last;
  } status_t;

  function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    logic [ROW_W+COL_W:0] prod;
    prod = (ROW_W+COL_W+1)'(row) * (ROW_W+COL_W+1)'(SCREEN_COLUMNS)
         + (ROW_W+COL_W+1)'(col);
    return prod[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tcw_ctrl.sv =====
// Controller state machine of the text console character writer.
// Depends on tcw_pkg; drives commands into tcw_datapath and owns the handshakes.
`default_nettype none

module tcw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire tcw_pkg::status_t st,
  output tcw_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCR_RD,
    S_SCR_WR,
    S_BLANK,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.ptr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.need_scroll) begin
            state_nxt = st.skip_copy ? S_BLANK : S_SCR_RD;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_SCR_RD: begin
        cmd.copy_rd = 1'b1;
        state_nxt   = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd.copy_wr = 1'b1;
        state_nxt   = st.copy_last ? S_BLANK : S_SCR_RD;
      end
      S_BLANK: begin
        cmd.blank_step = 1'b1;
        if (st.ptr_last) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> in_stall)
    else $error("input accepted in two consecutive cycles");

  a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not offered");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy_wr |-> $past(cmd.copy_rd))
    else $error("scroll write without a preceding read");

  a_load_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/tcw_datapath.sv =====
// Datapath of the text console character writer: screen memory, cursor,
// configuration registers and result register. Depends on tcw_pkg.
`default_nettype none

module tcw_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire tcw_pkg::cmd_t                    cmd,
  output tcw_pkg::status_t                      st,
  input  wire tcw_pkg::in_item_t                in_data,
  output tcw_pkg::out_item_t                    out_data,
  input  wire logic                             cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int COL_XW = tcw_pkg::COL_W + 1;
  localparam int ROW_XW = tcw_pkg::ROW_W + 1;
  localparam logic [COL_XW-1:0] TAB_MASK = COL_XW'(tcw_pkg::TAB_WIDTH - 1);

  logic [tcw_pkg::CELL_W-1:0]   mem [tcw_pkg::CELL_COUNT];

  logic [tcw_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [tcw_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic [tcw_pkg::ATTR_W-1:0]   attr_r;
  logic [tcw_pkg::SCROLL_W-1:0] stop_r;
  logic [tcw_pkg::PTR_W-1:0]    ptr_r, ptr_nxt;
  logic                         rd_ok_r;
  logic [tcw_pkg::CELL_W-1:0]   rdata_r;
  tcw_pkg::out_item_t           out_r;

  logic [tcw_pkg::CELL_W-1:0]   blank;
  logic [COL_XW-1:0]            pc;
  logic [ROW_XW-1:0]            pr;
  logic                         put_we;
  logic [tcw_pkg::ADDR_W-1:0]   put_addr;
  logic [tcw_pkg::CELL_W-1:0]   put_wdata;
  logic                         put_scroll;
  logic [tcw_pkg::START_W-1:0]  start;
  logic                         is_put;
  logic                         is_read;
  logic                         is_set;
  logic                         rd_ok;

  logic                         we;
  logic [tcw_pkg::PTR_W-1:0]    waddr;
  logic [tcw_pkg::CELL_W-1:0]   wdata;
  logic                         re;
  logic [tcw_pkg::PTR_W-1:0]    raddr;

  assign blank   = {attr_r, tcw_pkg::CH_SPACE};
  assign is_put  = (in_data.operation == tcw_pkg::OP_PUT);
  assign is_read = (in_data.operation == tcw_pkg::OP_READ);
  assign is_set  = (in_data.operation == tcw_pkg::OP_SET);
  assign rd_ok   = is_read &&
                   (in_data.cell_address < tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT));

  always_comb begin
    pc         = COL_XW'(col_r);
    pr         = ROW_XW'(row_r);
    put_we     = 1'b0;
    put_addr   = tcw_pkg::cell_index(row_r, col_r);
    put_wdata  = {attr_r, in_data.char_code};
    put_scroll = 1'b0;
    case (in_data.char_code)
      tcw_pkg::CH_BACKSPACE: begin
        if (col_r != '0) begin
          pc        = COL_XW'(col_r) - COL_XW'(1);
          put_we    = 1'b1;
          put_addr  = tcw_pkg::cell_index(row_r, col_r - tcw_pkg::COL_W'(1));
          put_wdata = blank;
        end
      end
      tcw_pkg::CH_TAB: begin
        pc = (COL_XW'(col_r) & ~TAB_MASK) + COL_XW'(tcw_pkg::TAB_WIDTH);
      end
      tcw_pkg::CH_RETURN: begin
        pc = '0;
      end
      tcw_pkg::CH_NEWLINE: begin
        pc = '0;
        pr = ROW_XW'(row_r) + ROW_XW'(1);
      end
      default: begin
        if (in_data.char_code >= tcw_pkg::CH_SPACE) begin
          put_we = 1'b1;
          pc     = COL_XW'(col_r) + COL_XW'(1);
        end
      end
    endcase
    if (pc >= COL_XW'(tcw_pkg::SCREEN_COLUMNS)) begin
      pc = '0;
      pr = pr + ROW_XW'(1);
    end
    if (pr >= ROW_XW'(tcw_pkg::SCREEN_ROWS)) begin
      pr         = ROW_XW'(tcw_pkg::SCREEN_ROWS - 1);
      put_scroll = 1'b1;
    end
  end

  assign start = tcw_pkg::START_W'(stop_r) * tcw_pkg::START_W'(tcw_pkg::SCREEN_COLUMNS);

  assign st.need_scroll = is_put && put_scroll;
  assign st.skip_copy   = (start >= tcw_pkg::START_W'(tcw_pkg::COPY_END));
  assign st.copy_last   = (ptr_r == tcw_pkg::PTR_W'(tcw_pkg::COPY_END - 1));
  assign st.ptr_last    = (ptr_r == tcw_pkg::PTR_W'(tcw_pkg::CELL_COUNT - 1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.accept && is_put) begin
      col_nxt = pc[tcw_pkg::COL_W-1:0];
      row_nxt = pr[tcw_pkg::ROW_W-1:0];
    end else if (cmd.accept && is_set) begin
      col_nxt = (in_data.new_column < tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLUMNS)) ?
                in_data.new_column : tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLUMNS - 1);
      row_nxt = (in_data.new_row < tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS)) ?
                in_data.new_row : tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1);
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.accept && st.need_scroll) begin
      ptr_nxt = st.skip_copy ? tcw_pkg::PTR_W'(tcw_pkg::COPY_END)
                             : start[tcw_pkg::PTR_W-1:0];
    end else if (cmd.clear_step || cmd.copy_wr || cmd.blank_step) begin
      ptr_nxt = ptr_r + tcw_pkg::PTR_W'(1);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr_r;
    wdata = '0;
    re    = 1'b0;
    raddr = ptr_r + tcw_pkg::PTR_W'(tcw_pkg::SCREEN_COLUMNS);
    if (cmd.clear_step) begin
      we = 1'b1;
    end else if (cmd.copy_wr) begin
      we    = 1'b1;
      wdata = rdata_r;
    end else if (cmd.blank_step) begin
      we    = 1'b1;
      wdata = blank;
    end else if (cmd.accept && is_put && put_we) begin
      we    = 1'b1;
      waddr = put_addr;
      wdata = put_wdata;
    end
    if (cmd.copy_rd) begin
      re = 1'b1;
    end else if (cmd.accept && rd_ok) begin
      re    = 1'b1;
      raddr = in_data.cell_address;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      attr_r  <= '0;
      stop_r  <= tcw_pkg::SCROLL_TOP_RESET;
      ptr_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ptr_r <= ptr_nxt;
      if (cmd.accept) begin
        rd_ok_r <= rd_ok;
      end
      if (cfg_we && cfg_index == tcw_pkg::CFG_TEXT_ATTRIBUTE) begin
        attr_r <= cfg_wdata[tcw_pkg::ATTR_W-1:0];
      end
      if (cfg_we && cfg_index == tcw_pkg::CFG_SCROLL_TOP) begin
        stop_r <= cfg_wdata[tcw_pkg::SCROLL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.cell_data       <= rd_ok_r ? rdata_r : '0;
      out_r.cursor_location <= tcw_pkg::cell_index(row_r, col_r);
      out_r.cursor_col_out  <= col_r;
      out_r.cursor_row_out  <= row_r;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== rtl/core/text_console_char_writer.sv =====
// Put, read and set-cursor items are handled one at a time: a new item is not taken
// until the result of the last one has been loaded into the result register.
// A put that scrolls reads and then writes each copied cell, then blanks each
// bottom-row cell; the copy is skipped when scroll_top is 24 or more.
// After synchronous reset a clearing pass zeroes the screen memory while input
// transfers are held off; configuration writes are taken throughout.
`default_nettype none

module text_console_char_writer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire tcw_pkg::in_item_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output tcw_pkg::out_item_t                    out_data,
  input  wire logic                             cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t st;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  tcw_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

`default_nettype wire
